// ===== design/rrds_pkg.sv =====
// Package with the shared constants, types and helpers of the dispatch select block.
package rrds_pkg;

  localparam int WAIT_SLOTS  = 8;
  localparam int SLOT_W      = 3;
  localparam int REG_COUNT   = 32;
  localparam int REG_W       = 5;
  localparam int UNIT_COUNT  = 4;
  localparam int UNIT_W      = 2;
  localparam int DATA_WIDTH  = 32;
  localparam int OP_W        = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_WRITE,
    CMD_TICK,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_RESP
  } back_state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [SLOT_W-1:0]     slot;
    logic [REG_W-1:0]      src_one;
    logic                  has_src_two;
    logic [REG_W-1:0]      src_two;
    logic [REG_W-1:0]      dest;
    logic [UNIT_W-1:0]     unit;
    logic                  first_ready;
    logic                  second_ready;
    logic [DATA_WIDTH-1:0] write_value;
    logic [REG_COUNT-1:0]  pending_writes;
    logic [UNIT_COUNT-1:0] free_units;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [REG_W-1:0]  src_one;
    logic              has_src_two;
    logic [REG_W-1:0]  src_two;
    logic [REG_W-1:0]  dest;
    logic [UNIT_W-1:0] unit;
    logic              first_ready;
    logic              second_ready;
  } entry_t;

  typedef struct packed {
    logic                  we;
    logic [REG_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [REG_W-1:0]      raddr_a;
    logic [REG_W-1:0]      raddr_b;
  } rf_req_t;

  // One-hot scoreboard bit of a register; registers beyond the file mark nothing.
  function automatic logic [REG_COUNT-1:0] reg_onehot(input logic [REG_W-1:0] r);
    logic [REG_COUNT-1:0] bits;
    bits = '0;
    if (int'(r) < REG_COUNT) begin
      bits[r] = 1'b1;
    end
    return bits;
  endfunction

endpackage

// ===== design/rrds_front.sv =====
// Front part: accepts items, decodes the operation and queues them for the back part.
module rrds_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rrds_pkg::OP_W-1:0]            operation_i,
  input  logic [rrds_pkg::SLOT_W-1:0]          slot_i,
  input  logic [rrds_pkg::REG_W-1:0]           src_one_i,
  input  logic                                 has_src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]           src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]           dest_in_i,
  input  logic [rrds_pkg::UNIT_W-1:0]          unit_in_i,
  input  logic                                 first_ready_i,
  input  logic                                 second_ready_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0]      write_value_i,
  input  logic [rrds_pkg::REG_COUNT-1:0]       pending_writes_i,
  input  logic [rrds_pkg::UNIT_COUNT-1:0]      free_units_i,
  output logic                                 busy_o,
  input  logic                                 pop_i,
  output rrds_pkg::queue_head_t                head_o
);

  rrds_pkg::item_t                   queue_q [rrds_pkg::QUEUE_DEPTH];
  logic [rrds_pkg::QUEUE_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rrds_pkg::QUEUE_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rrds_pkg::QUEUE_AW:0]       count_q, count_d;
  rrds_pkg::item_t                   item_in;
  logic                              push;
  logic                              pop;

  always_comb begin
    item_in.slot           = slot_i;
    item_in.src_one        = src_one_i;
    item_in.has_src_two    = has_src_two_i;
    item_in.src_two        = src_two_i;
    item_in.dest           = dest_in_i;
    item_in.unit           = unit_in_i;
    item_in.first_ready    = first_ready_i;
    item_in.second_ready   = second_ready_i;
    item_in.write_value    = write_value_i;
    item_in.pending_writes = pending_writes_i;
    item_in.free_units     = free_units_i;
    unique case (operation_i)
      rrds_pkg::OP_INSERT: item_in.cmd = rrds_pkg::CMD_INSERT;
      rrds_pkg::OP_WRITE:  item_in.cmd = rrds_pkg::CMD_WRITE;
      rrds_pkg::OP_TICK:   item_in.cmd = rrds_pkg::CMD_TICK;
      rrds_pkg::OP_NONE:   item_in.cmd = rrds_pkg::CMD_NOP;
    endcase
  end

  assign busy_o = (count_q == (rrds_pkg::QUEUE_AW + 1)'(rrds_pkg::QUEUE_DEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (count_q != '0);

  // The depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

// ===== design/rrds_regfile.sv =====
// Register file with two registered read ports and per-register valid bits for reset.
module rrds_regfile (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rrds_pkg::rf_req_t               req_i,
  output logic [rrds_pkg::DATA_WIDTH-1:0] rdata_a_o,
  output logic [rrds_pkg::DATA_WIDTH-1:0] rdata_b_o
);

  logic [rrds_pkg::DATA_WIDTH-1:0] mem [rrds_pkg::REG_COUNT];
  logic [rrds_pkg::REG_COUNT-1:0]  vld_q;
  logic [rrds_pkg::DATA_WIDTH-1:0] rdata_a_q;
  logic [rrds_pkg::DATA_WIDTH-1:0] rdata_b_q;

  // A register never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_a_q <= vld_q[req_i.raddr_a] ? mem[req_i.raddr_a] : '0;
      rdata_b_q <= vld_q[req_i.raddr_b] ? mem[req_i.raddr_b] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/rrds_back.sv =====
// Back part: wait buffer, scoreboard, round-robin scan and result generation.
module rrds_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrds_pkg::queue_head_t            head_i,
  output logic                             pop_o,
  output rrds_pkg::rf_req_t                rf_req_o,
  input  logic [rrds_pkg::DATA_WIDTH-1:0]  rdata_a_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0]  rdata_b_i,
  output logic                             done_o,
  output logic                             dispatched_o,
  output logic [rrds_pkg::SLOT_W-1:0]      from_slot_o,
  output logic [rrds_pkg::UNIT_W-1:0]      unit_out_o,
  output logic [rrds_pkg::DATA_WIDTH-1:0]  operand_one_o,
  output logic [rrds_pkg::DATA_WIDTH-1:0]  operand_two_o,
  output logic [rrds_pkg::REG_W-1:0]       dest_out_o,
  output logic [rrds_pkg::REG_COUNT-1:0]   pending_reads_o
);

  rrds_pkg::back_state_e           state_q, state_d;
  rrds_pkg::item_t                 item_q;
  rrds_pkg::entry_t                entry_q [rrds_pkg::WAIT_SLOTS];
  logic [rrds_pkg::REG_COUNT-1:0]  board_q [rrds_pkg::WAIT_SLOTS];
  logic [rrds_pkg::WAIT_SLOTS-1:0] busy_q;
  logic [rrds_pkg::SLOT_W-1:0]     scan_q;

  logic [rrds_pkg::WAIT_SLOTS-1:0] eligible;
  logic                            found;
  logic [rrds_pkg::SLOT_W-1:0]     pick;
  logic [rrds_pkg::SLOT_W-1:0]     pick_next;
  logic                            exec;
  logic                            do_insert;
  logic                            do_write;
  logic                            do_take;
  rrds_pkg::entry_t                picked;
  rrds_pkg::entry_t                new_entry;
  logic [rrds_pkg::REG_COUNT-1:0]  pending_or;

  logic                            res_disp_q;
  logic [rrds_pkg::SLOT_W-1:0]     res_slot_q;
  logic [rrds_pkg::UNIT_W-1:0]     res_unit_q;
  logic [rrds_pkg::REG_W-1:0]      res_dest_q;
  logic                            res_has2_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      rrds_pkg::BK_IDLE, rrds_pkg::BK_RESP: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = rrds_pkg::BK_EXEC;
        end else begin
          state_d = rrds_pkg::BK_IDLE;
        end
      end
      rrds_pkg::BK_EXEC: state_d = rrds_pkg::BK_RESP;
      default:           state_d = rrds_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrds_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i.item;
    end
  end

  // A slot may go when it is occupied, no unready source has a write in flight
  // and its unit exists and is free.
  always_comb begin
    for (int s = 0; s < rrds_pkg::WAIT_SLOTS; s++) begin
      eligible[s] = busy_q[s]
          && !((item_q.pending_writes & rrds_pkg::reg_onehot(entry_q[s].src_one)) != '0
               && !entry_q[s].first_ready)
          && !(entry_q[s].has_src_two
               && (item_q.pending_writes & rrds_pkg::reg_onehot(entry_q[s].src_two)) != '0
               && !entry_q[s].second_ready)
          && (int'(entry_q[s].unit) < rrds_pkg::UNIT_COUNT)
          && item_q.free_units[entry_q[s].unit];
    end
  end

  // Round-robin search starting at the scan pointer.
  always_comb begin
    logic [rrds_pkg::SLOT_W:0] idx;
    logic [rrds_pkg::SLOT_W:0] nxt;
    found = 1'b0;
    pick  = '0;
    for (int n = 0; n < rrds_pkg::WAIT_SLOTS; n++) begin
      idx = {1'b0, scan_q} + (rrds_pkg::SLOT_W + 1)'(n);
      if (idx >= (rrds_pkg::SLOT_W + 1)'(rrds_pkg::WAIT_SLOTS)) begin
        idx = idx - (rrds_pkg::SLOT_W + 1)'(rrds_pkg::WAIT_SLOTS);
      end
      if (!found && eligible[idx[rrds_pkg::SLOT_W-1:0]]) begin
        found = 1'b1;
        pick  = idx[rrds_pkg::SLOT_W-1:0];
      end
    end
    nxt = {1'b0, pick} + 1'b1;
    if (nxt >= (rrds_pkg::SLOT_W + 1)'(rrds_pkg::WAIT_SLOTS)) begin
      nxt = '0;
    end
    pick_next = nxt[rrds_pkg::SLOT_W-1:0];
  end

  assign picked    = entry_q[pick];
  assign exec      = (state_q == rrds_pkg::BK_EXEC);
  assign do_insert = exec && (item_q.cmd == rrds_pkg::CMD_INSERT)
                     && (int'(item_q.slot) < rrds_pkg::WAIT_SLOTS);
  assign do_write  = exec && (item_q.cmd == rrds_pkg::CMD_WRITE)
                     && (int'(item_q.dest) < rrds_pkg::REG_COUNT);
  assign do_take   = exec && (item_q.cmd == rrds_pkg::CMD_TICK) && found;

  always_comb begin
    new_entry.src_one      = item_q.src_one;
    new_entry.has_src_two  = item_q.has_src_two;
    new_entry.src_two      = item_q.src_two;
    new_entry.dest         = item_q.dest;
    new_entry.unit         = item_q.unit;
    new_entry.first_ready  = item_q.first_ready;
    new_entry.second_ready = item_q.second_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      scan_q <= '0;
      for (int s = 0; s < rrds_pkg::WAIT_SLOTS; s++) begin
        board_q[s] <= '0;
      end
    end else if (do_insert) begin
      busy_q[item_q.slot]  <= 1'b1;
      board_q[item_q.slot] <= rrds_pkg::reg_onehot(item_q.src_one)
          | (item_q.has_src_two ? rrds_pkg::reg_onehot(item_q.src_two) : '0);
    end else if (do_take) begin
      // The row only ever held the sources, so clearing them empties it.
      busy_q[pick]  <= 1'b0;
      board_q[pick] <= '0;
      scan_q        <= pick_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      entry_q[item_q.slot] <= new_entry;
    end
    if (exec) begin
      res_disp_q <= do_take;
      res_slot_q <= do_take ? pick : '0;
      res_unit_q <= do_take ? picked.unit : '0;
      res_dest_q <= do_take ? picked.dest : '0;
      res_has2_q <= do_take && picked.has_src_two;
    end
  end

  always_comb begin
    rf_req_o.we      = do_write;
    rf_req_o.waddr   = item_q.dest;
    rf_req_o.wdata   = item_q.write_value;
    rf_req_o.re      = exec;
    rf_req_o.raddr_a = picked.src_one;
    rf_req_o.raddr_b = picked.src_two;
  end

  // The pending reads are always the OR of all scoreboard rows.
  always_comb begin
    pending_or = '0;
    for (int s = 0; s < rrds_pkg::WAIT_SLOTS; s++) begin
      pending_or = pending_or | board_q[s];
    end
  end

  assign done_o          = (state_q == rrds_pkg::BK_RESP);
  assign dispatched_o    = res_disp_q;
  assign from_slot_o     = res_slot_q;
  assign unit_out_o      = res_unit_q;
  assign dest_out_o      = res_dest_q;
  assign operand_one_o   = res_disp_q ? rdata_a_i : '0;
  assign operand_two_o   = res_has2_q ? rdata_b_i : '0;
  assign pending_reads_o = pending_or;

endmodule

// ===== design/round_robin_dispatch_select.sv =====
// An accepted item passes through the queue and then the back part's execute and respond steps.
// The back part takes one item at a time around the registered register file read and can
// pop the next item in its respond step; a two-item queue sits in front.
// Reset clears the slot busy bits, scoreboard, register file valid bits and scan pointer.
// Each item gives exactly one result, held for one cycle; the receiver cannot stall.
module round_robin_dispatch_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rrds_pkg::OP_W-1:0]            operation_i,
  input  logic [rrds_pkg::SLOT_W-1:0]          slot_i,
  input  logic [rrds_pkg::REG_W-1:0]           src_one_i,
  input  logic                                 has_src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]           src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]           dest_in_i,
  input  logic [rrds_pkg::UNIT_W-1:0]          unit_in_i,
  input  logic                                 first_ready_i,
  input  logic                                 second_ready_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0]      write_value_i,
  input  logic [rrds_pkg::REG_COUNT-1:0]       pending_writes_i,
  input  logic [rrds_pkg::UNIT_COUNT-1:0]      free_units_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic                                 dispatched_o,
  output logic [rrds_pkg::SLOT_W-1:0]          from_slot_o,
  output logic [rrds_pkg::UNIT_W-1:0]          unit_out_o,
  output logic [rrds_pkg::DATA_WIDTH-1:0]      operand_one_o,
  output logic [rrds_pkg::DATA_WIDTH-1:0]      operand_two_o,
  output logic [rrds_pkg::REG_W-1:0]           dest_out_o,
  output logic [rrds_pkg::REG_COUNT-1:0]       pending_reads_o
);

  rrds_pkg::queue_head_t           head;
  logic                            pop;
  rrds_pkg::rf_req_t               rf_req;
  logic [rrds_pkg::DATA_WIDTH-1:0] rdata_a;
  logic [rrds_pkg::DATA_WIDTH-1:0] rdata_b;

  rrds_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .src_one_i        (src_one_i),
    .has_src_two_i    (has_src_two_i),
    .src_two_i        (src_two_i),
    .dest_in_i        (dest_in_i),
    .unit_in_i        (unit_in_i),
    .first_ready_i    (first_ready_i),
    .second_ready_i   (second_ready_i),
    .write_value_i    (write_value_i),
    .pending_writes_i (pending_writes_i),
    .free_units_i     (free_units_i),
    .busy_o           (busy_o),
    .pop_i            (pop),
    .head_o           (head)
  );

  rrds_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rf_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  rrds_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .rf_req_o        (rf_req),
    .rdata_a_i       (rdata_a),
    .rdata_b_i       (rdata_b),
    .done_o          (done_o),
    .dispatched_o    (dispatched_o),
    .from_slot_o     (from_slot_o),
    .unit_out_o      (unit_out_o),
    .operand_one_o   (operand_one_o),
    .operand_two_o   (operand_two_o),
    .dest_out_o      (dest_out_o),
    .pending_reads_o (pending_reads_o)
  );

endmodule

// ===== dv/dispatch_checker.sv =====
// Checker that predicts every result of the dispatch select block and compares it with the strobes.
`timescale 1ns / 1ps

module dispatch_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [rrds_pkg::OP_W-1:0]       operation_i,
  input  logic [rrds_pkg::SLOT_W-1:0]     slot_i,
  input  logic [rrds_pkg::REG_W-1:0]      src_one_i,
  input  logic                            has_src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]      src_two_i,
  input  logic [rrds_pkg::REG_W-1:0]      dest_in_i,
  input  logic [rrds_pkg::UNIT_W-1:0]     unit_in_i,
  input  logic                            first_ready_i,
  input  logic                            second_ready_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0] write_value_i,
  input  logic [rrds_pkg::REG_COUNT-1:0]  pending_writes_i,
  input  logic [rrds_pkg::UNIT_COUNT-1:0] free_units_i,
  input  logic                            done_i,
  input  logic                            dispatched_i,
  input  logic [rrds_pkg::SLOT_W-1:0]     from_slot_i,
  input  logic [rrds_pkg::UNIT_W-1:0]     unit_out_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0] operand_one_i,
  input  logic [rrds_pkg::DATA_WIDTH-1:0] operand_two_i,
  input  logic [rrds_pkg::REG_W-1:0]      dest_out_i,
  input  logic [rrds_pkg::REG_COUNT-1:0]  pending_reads_i,
  output int                              fail_count_o,
  output int                              outstanding_o,
  output int                              items_o,
  output int                              results_o,
  output int                              dispatches_o,
  output int                              empty_ticks_o
);
  import rrds_pkg::*;

  typedef struct packed {
    logic                  dispatched;
    logic [SLOT_W-1:0]     from_slot;
    logic [UNIT_W-1:0]     unit;
    logic [DATA_WIDTH-1:0] operand_one;
    logic [DATA_WIDTH-1:0] operand_two;
    logic [REG_W-1:0]      dest;
    logic [REG_COUNT-1:0]  pending_reads;
  } dispatch_result_t;

  logic                  slot_held [WAIT_SLOTS];
  entry_t                waiting [WAIT_SLOTS];
  logic [REG_COUNT-1:0]  src_board [WAIT_SLOTS];
  logic [REG_COUNT-1:0]  reads_outstanding;
  logic [DATA_WIDTH-1:0] regfile [REG_COUNT];
  logic [SLOT_W-1:0]     scan_ptr;

  dispatch_result_t expected_q [$];
  int failures    = 0;
  int items_seen  = 0;
  int results_got = 0;
  int dispatches  = 0;
  int empty_ticks = 0;

  assign fail_count_o  = failures;
  assign items_o       = items_seen;
  assign results_o     = results_got;
  assign dispatches_o  = dispatches;
  assign empty_ticks_o = empty_ticks;

  initial begin
    reads_outstanding = '0;
    scan_ptr          = '0;
    for (int s = 0; s < WAIT_SLOTS; s++) begin
      slot_held[s] = 1'b0;
      waiting[s]   = '0;
      src_board[s] = '0;
    end
    for (int r = 0; r < REG_COUNT; r++) begin
      regfile[r] = '0;
    end
  end

  function automatic logic [REG_COUNT-1:0] reg_mask(input logic [REG_W-1:0] r);
    logic [REG_COUNT-1:0] m;
    m = '0;
    if (int'(r) < REG_COUNT) begin
      m[r] = 1'b1;
    end
    return m;
  endfunction

  function automatic void refresh_reads();
    reads_outstanding = '0;
    for (int s = 0; s < WAIT_SLOTS; s++) begin
      reads_outstanding |= src_board[s];
    end
  endfunction

  // Applies the item on the input ports to the predicted state and returns its result.
  function automatic dispatch_result_t predict_dispatch();
    dispatch_result_t res;
    logic [SLOT_W-1:0] idx;
    entry_t            e;
    logic              found;
    logic              blocked;
    res   = '0;
    found = 1'b0;
    case (operation_i)
      OP_INSERT: begin
        if (int'(slot_i) < WAIT_SLOTS) begin
          e.src_one      = src_one_i;
          e.has_src_two  = has_src_two_i;
          e.src_two      = src_two_i;
          e.dest         = dest_in_i;
          e.unit         = unit_in_i;
          e.first_ready  = first_ready_i;
          e.second_ready = second_ready_i;
          waiting[slot_i]   = e;
          slot_held[slot_i] = 1'b1;
          src_board[slot_i] = reg_mask(src_one_i) |
                              (has_src_two_i ? reg_mask(src_two_i) : '0);
          refresh_reads();
        end
      end
      OP_WRITE: begin
        if (int'(dest_in_i) < REG_COUNT) begin
          regfile[dest_in_i] = write_value_i;
        end
      end
      OP_TICK: begin
        for (int n = 0; n < WAIT_SLOTS; n++) begin
          idx = SLOT_W'((int'(scan_ptr) + n) % WAIT_SLOTS);
          e   = waiting[idx];
          // A source with a write in flight holds the entry back unless it was ready at insert.
          blocked = !slot_held[idx] ||
                    (((pending_writes_i & reg_mask(e.src_one)) != '0) && !e.first_ready) ||
                    (e.has_src_two && ((pending_writes_i & reg_mask(e.src_two)) != '0) &&
                     !e.second_ready) ||
                    (int'(e.unit) >= UNIT_COUNT) || !free_units_i[e.unit];
          if (!found && !blocked) begin
            found           = 1'b1;
            res.dispatched  = 1'b1;
            res.from_slot   = idx;
            res.unit        = e.unit;
            res.operand_one = (int'(e.src_one) < REG_COUNT) ? regfile[e.src_one] : '0;
            if (e.has_src_two && int'(e.src_two) < REG_COUNT) begin
              res.operand_two = regfile[e.src_two];
            end
            res.dest = e.dest;
            src_board[idx] &= ~(reg_mask(e.src_one) |
                                (e.has_src_two ? reg_mask(e.src_two) : '0));
            refresh_reads();
            slot_held[idx] = 1'b0;
            scan_ptr       = SLOT_W'((int'(idx) + 1) % WAIT_SLOTS);
          end
        end
      end
      default: ;
    endcase
    res.pending_reads = reads_outstanding;
    return res;
  endfunction

  always @(posedge clk_i) begin
    dispatch_result_t want;
    dispatch_result_t got;
    if (rst_ni) begin
      if (done_i) begin
        results_got++;
        got.dispatched    = dispatched_i;
        got.from_slot     = from_slot_i;
        got.unit          = unit_out_i;
        got.operand_one   = operand_one_i;
        got.operand_two   = operand_two_i;
        got.dest          = dest_out_i;
        got.pending_reads = pending_reads_i;
        if (expected_q.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result strobe with no item outstanding: disp=%0b slot=%0d", $realtime,
                     got.dispatched, got.from_slot);
          end
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (failures < 10) begin
              $display("%0t: mismatch, expected disp=%0b slot=%0d unit=%0d op1=%h op2=%h",
                       $realtime, want.dispatched, want.from_slot, want.unit,
                       want.operand_one, want.operand_two);
              $display("    dest=%0d reads=%h; got disp=%0b slot=%0d unit=%0d op1=%h",
                       want.dest, want.pending_reads, got.dispatched, got.from_slot,
                       got.unit, got.operand_one);
              $display("    op2=%h dest=%0d reads=%h", got.operand_two, got.dest,
                       got.pending_reads);
            end
            failures++;
          end
        end
      end
      if (start_i && !busy_i) begin
        items_seen++;
        want = predict_dispatch();
        if (operation_i == OP_TICK) begin
          if (want.dispatched) begin
            dispatches++;
          end else begin
            empty_ticks++;
          end
        end
        expected_q.push_back(want);
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the dispatch select testbench: clock, reset, item stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import rrds_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 1000;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  start_i          = 1'b0;
  logic [OP_W-1:0]       operation_i      = '0;
  logic [SLOT_W-1:0]     slot_i           = '0;
  logic [REG_W-1:0]      src_one_i        = '0;
  logic                  has_src_two_i    = 1'b0;
  logic [REG_W-1:0]      src_two_i        = '0;
  logic [REG_W-1:0]      dest_in_i        = '0;
  logic [UNIT_W-1:0]     unit_in_i        = '0;
  logic                  first_ready_i    = 1'b0;
  logic                  second_ready_i   = 1'b0;
  logic [DATA_WIDTH-1:0] write_value_i    = '0;
  logic [REG_COUNT-1:0]  pending_writes_i = '0;
  logic [UNIT_COUNT-1:0] free_units_i     = '0;

  logic                  busy_o;
  logic                  done_o;
  logic                  dispatched_o;
  logic [SLOT_W-1:0]     from_slot_o;
  logic [UNIT_W-1:0]     unit_out_o;
  logic [DATA_WIDTH-1:0] operand_one_o;
  logic [DATA_WIDTH-1:0] operand_two_o;
  logic [REG_W-1:0]      dest_out_o;
  logic [REG_COUNT-1:0]  pending_reads_o;

  int fail_count;
  int outstanding;
  int items_checked;
  int results_seen;
  int dispatch_count;
  int empty_tick_count;
  int stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  round_robin_dispatch_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .src_one_i        (src_one_i),
    .has_src_two_i    (has_src_two_i),
    .src_two_i        (src_two_i),
    .dest_in_i        (dest_in_i),
    .unit_in_i        (unit_in_i),
    .first_ready_i    (first_ready_i),
    .second_ready_i   (second_ready_i),
    .write_value_i    (write_value_i),
    .pending_writes_i (pending_writes_i),
    .free_units_i     (free_units_i),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .dispatched_o     (dispatched_o),
    .from_slot_o      (from_slot_o),
    .unit_out_o       (unit_out_o),
    .operand_one_o    (operand_one_o),
    .operand_two_o    (operand_two_o),
    .dest_out_o       (dest_out_o),
    .pending_reads_o  (pending_reads_o)
  );

  dispatch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .src_one_i        (src_one_i),
    .has_src_two_i    (has_src_two_i),
    .src_two_i        (src_two_i),
    .dest_in_i        (dest_in_i),
    .unit_in_i        (unit_in_i),
    .first_ready_i    (first_ready_i),
    .second_ready_i   (second_ready_i),
    .write_value_i    (write_value_i),
    .pending_writes_i (pending_writes_i),
    .free_units_i     (free_units_i),
    .done_i           (done_o),
    .dispatched_i     (dispatched_o),
    .from_slot_i      (from_slot_o),
    .unit_out_i       (unit_out_o),
    .operand_one_i    (operand_one_o),
    .operand_two_i    (operand_two_o),
    .dest_out_i       (dest_out_o),
    .pending_reads_i  (pending_reads_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .items_o          (items_checked),
    .results_o        (results_seen),
    .dispatches_o     (dispatch_count),
    .empty_ticks_o    (empty_tick_count)
  );

  // The run is stopped if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic item_t noise_item();
    item_t it;
    it.cmd            = CMD_NOP;
    it.slot           = SLOT_W'($urandom);
    it.src_one        = REG_W'($urandom);
    it.has_src_two    = 1'($urandom);
    it.src_two        = REG_W'($urandom);
    it.dest           = REG_W'($urandom);
    it.unit           = UNIT_W'($urandom);
    it.first_ready    = 1'($urandom);
    it.second_ready   = 1'($urandom);
    it.write_value    = DATA_WIDTH'($urandom);
    it.pending_writes = REG_COUNT'($urandom);
    it.free_units     = UNIT_COUNT'($urandom);
    return it;
  endfunction

  function automatic item_t write_item(input logic [REG_W-1:0] r,
                                       input logic [DATA_WIDTH-1:0] v);
    item_t it;
    it             = noise_item();
    it.cmd         = CMD_WRITE;
    it.dest        = r;
    it.write_value = v;
    return it;
  endfunction

  function automatic item_t insert_item(input logic [SLOT_W-1:0] s, input logic [REG_W-1:0] a,
                                        input logic two, input logic [REG_W-1:0] b,
                                        input logic [REG_W-1:0] d, input logic [UNIT_W-1:0] u,
                                        input logic ra, input logic rb);
    item_t it;
    it              = noise_item();
    it.cmd          = CMD_INSERT;
    it.slot         = s;
    it.src_one      = a;
    it.has_src_two  = two;
    it.src_two      = b;
    it.dest         = d;
    it.unit         = u;
    it.first_ready  = ra;
    it.second_ready = rb;
    return it;
  endfunction

  function automatic item_t tick_item(input logic [REG_COUNT-1:0] pw,
                                      input logic [UNIT_COUNT-1:0] fu);
    item_t it;
    it                = noise_item();
    it.cmd            = CMD_TICK;
    it.pending_writes = pw;
    it.free_units     = fu;
    return it;
  endfunction

  // Offers one item and returns at the edge that accepts it, with start still high.
  task automatic send_item(input item_t it, input bit may_idle);
    if (may_idle && $urandom_range(99) < 25) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
    start_i          <= 1'b1;
    operation_i      <= it.cmd;
    slot_i           <= it.slot;
    src_one_i        <= it.src_one;
    has_src_two_i    <= it.has_src_two;
    src_two_i        <= it.src_two;
    dest_in_i        <= it.dest;
    unit_in_i        <= it.unit;
    first_ready_i    <= it.first_ready;
    second_ready_i   <= it.second_ready;
    write_value_i    <= it.write_value;
    pending_writes_i <= it.pending_writes;
    free_units_i     <= it.free_units;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    item_t it;
    int    pick;
    bit    fill;
    bit    quiet;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, blocking reasons, an overwrite and the round-robin order.
    send_item(write_item(5'd0, '1), 1'b1);
    send_item(write_item(5'd31, '1), 1'b1);
    send_item(write_item(5'd5, 32'hA5A5_5A5A), 1'b1);
    send_item(insert_item(3'd0, 5'd0, 1'b1, 5'd31, 5'd31, 2'd3, 1'b0, 1'b0), 1'b1);
    send_item(tick_item('1, '1), 1'b1);
    send_item(tick_item('0, '0), 1'b1);
    send_item(tick_item('0, 4'b1000), 1'b1);
    send_item(insert_item(3'd7, 5'd31, 1'b0, 5'd5, 5'd0, 2'd0, 1'b1, 1'b0), 1'b1);
    send_item(insert_item(3'd3, 5'd5, 1'b1, 5'd5, 5'd17, 2'd1, 1'b0, 1'b1), 1'b1);
    send_item(insert_item(3'd3, 5'd5, 1'b1, 5'd0, 5'd17, 2'd2, 1'b1, 1'b1), 1'b1);
    it = noise_item();
    send_item(it, 1'b1);
    send_item(tick_item('1, '1), 1'b1);
    send_item(tick_item('1, '1), 1'b1);
    send_item(write_item(5'd31, '0), 1'b1);
    send_item(write_item(5'd0, '0), 1'b1);
    send_item(insert_item(3'd1, 5'd31, 1'b1, 5'd0, 5'd3, 2'd0, 1'b0, 1'b0), 1'b1);
    send_item(tick_item(32'h8000_0001, '1), 1'b1);
    send_item(tick_item('0, 4'b0001), 1'b1);
    send_item(tick_item('0, '1), 1'b1);

    // Random part: fill bursts at the start of every hundred items, then a mix that drains.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fill  = (i % 100) < 25;
      quiet = (i >= 400) && (i < 600);
      pick  = $urandom_range(99);
      it    = noise_item();
      if (pick < (fill ? 70 : 25)) begin
        it.cmd = CMD_INSERT;
      end else if (pick < (fill ? 85 : 45)) begin
        it.cmd = CMD_WRITE;
      end else if (pick < 96) begin
        it.cmd = CMD_TICK;
        pick   = $urandom_range(19);
        if (pick < 6) begin
          it.pending_writes = '0;
        end else if (pick < 13) begin
          it.pending_writes = (REG_COUNT'(1) << $urandom_range(REG_COUNT - 1)) |
                              (REG_COUNT'(1) << $urandom_range(REG_COUNT - 1));
        end else if (pick == 19) begin
          it.pending_writes = '1;
        end
        if ($urandom_range(9) < 7) begin
          it.free_units = '1;
        end
      end
      send_item(it, !quiet);
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d items (inserts, writes, ticks, no-ops), %0d results checked",
             items_checked, results_seen);
    $display("summary: %0d dispatches, %0d ticks with nothing dispatched",
             dispatch_count, empty_tick_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
